### sv/threshold_centroid_defines.svh
// Assertion macros shared by the threshold and centroid RTL.
`ifndef THRESHOLD_CENTROID_DEFINES_SVH
`define THRESHOLD_CENTROID_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TC_ASSERT_NOW(label, cond, check, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |-> (check)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TC_ASSERT_NEXT(label, cond, check, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (check)) else $error(msg);

`endif

### sv/tc_pkg.sv
// Shared types, constants and helpers for the threshold and centroid block.
`timescale 1ns / 1ps
`default_nettype none

package tc_pkg;

    // Field and state widths.
    localparam int PIX_W     = 8;
    localparam int DIM_W     = 13;
    localparam int POS_W     = 12;
    localparam int SUM_W     = 36;
    localparam int CNT_W     = 25;
    localparam int LIM_W     = 17;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

    // Reset values and pixel codes.
    localparam logic [PIX_W-1:0] RESET_THRESHOLD = 8'd100;
    localparam logic [DIM_W-1:0] RESET_WIDTH     = 13'd320;
    localparam logic [DIM_W-1:0] RESET_HEIGHT    = 13'd240;
    localparam logic [PIX_W-1:0] FG_VALUE        = 8'hFF;
    localparam logic [PIX_W-1:0] BG_VALUE        = 8'h00;

    // Job queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // One classified pixel on its way to the back end.
    typedef struct packed {
        logic             fg;
        logic             last;
        logic [SUM_W-1:0] row_sum;
        logic [SUM_W-1:0] col_sum;
        logic [CNT_W-1:0] count;
    } tc_job_t;

    // Configuration write transaction.
    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [DIM_W-1:0]     data;
    } tc_cfg_wr_t;

    // Last valid position for a dimension: zero counts as one, large values saturate.
    function automatic logic [LIM_W-1:0] clamp_last(input logic [DIM_W-1:0] v,
                                                    input logic [LIM_W-1:0] maxv);
        logic [LIM_W-1:0] ext;
        logic [LIM_W-1:0] res;
        begin
            ext = {{(LIM_W-DIM_W){1'b0}}, v};
            if (v == '0)
            begin
                res = '0;
            end
            else if (ext > maxv)
            begin
                res = maxv - 1'b1;
            end
            else
            begin
                res = ext - 1'b1;
            end
            return res;
        end
    endfunction

endpackage

`default_nettype wire

### sv/tc_front.sv
// Front end: configuration registers, thresholding, raster position and running sums.
`timescale 1ns / 1ps
`default_nettype none
`include "threshold_centroid_defines.svh"

module tc_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire tc_pkg::tc_cfg_wr_t       cfg_wr,
    input  wire logic                     accept,
    input  wire logic [tc_pkg::PIX_W-1:0] pixel,
    output tc_pkg::tc_job_t               job
);

    localparam logic [tc_pkg::LIM_W-1:0] MAX_W_L = tc_pkg::LIM_W'(MAX_WIDTH);
    localparam logic [tc_pkg::LIM_W-1:0] MAX_H_L = tc_pkg::LIM_W'(MAX_HEIGHT);

    logic [tc_pkg::PIX_W-1:0] threshold_reg;
    logic [tc_pkg::LIM_W-1:0] width_last_reg;
    logic [tc_pkg::LIM_W-1:0] height_last_reg;

    logic [tc_pkg::POS_W-1:0] row_pos_reg;
    logic [tc_pkg::POS_W-1:0] col_pos_reg;
    logic [tc_pkg::SUM_W-1:0] row_sum_reg;
    logic [tc_pkg::SUM_W-1:0] col_sum_reg;
    logic [tc_pkg::CNT_W-1:0] fg_count_reg;

    logic [tc_pkg::POS_W-1:0] row_pos_next;
    logic [tc_pkg::POS_W-1:0] col_pos_next;
    logic [tc_pkg::SUM_W-1:0] row_sum_next;
    logic [tc_pkg::SUM_W-1:0] col_sum_next;
    logic [tc_pkg::CNT_W-1:0] fg_count_next;

    logic fg;
    logic row_end;
    logic last;

    // Configuration writes store the clamped last index so the compare stays narrow.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= tc_pkg::RESET_THRESHOLD;
            width_last_reg  <= tc_pkg::clamp_last(tc_pkg::RESET_WIDTH, MAX_W_L);
            height_last_reg <= tc_pkg::clamp_last(tc_pkg::RESET_HEIGHT, MAX_H_L);
        end
        else if (cfg_wr.valid)
        begin
            case (cfg_wr.index)
                tc_pkg::REG_THRESHOLD: threshold_reg <= cfg_wr.data[tc_pkg::PIX_W-1:0];
                tc_pkg::REG_WIDTH:     width_last_reg <= tc_pkg::clamp_last(cfg_wr.data,
                                                                           MAX_W_L);
                tc_pkg::REG_HEIGHT:    height_last_reg <= tc_pkg::clamp_last(cfg_wr.data,
                                                                            MAX_H_L);
                default:               ;
            endcase
        end
    end

    // Classify the pixel and find where it sits in the frame.
    always_comb
    begin
        fg      = pixel >= threshold_reg;
        row_end = {{(tc_pkg::LIM_W-tc_pkg::POS_W){1'b0}}, col_pos_reg} >= width_last_reg;
        last    = row_end &&
                  ({{(tc_pkg::LIM_W-tc_pkg::POS_W){1'b0}}, row_pos_reg} >= height_last_reg);
    end

    // Running sums including the current pixel.
    always_comb
    begin
        row_sum_next  = row_sum_reg;
        col_sum_next  = col_sum_reg;
        fg_count_next = fg_count_reg;
        if (fg)
        begin
            row_sum_next  = row_sum_reg +
                            {{(tc_pkg::SUM_W-tc_pkg::POS_W){1'b0}}, row_pos_reg};
            col_sum_next  = col_sum_reg +
                            {{(tc_pkg::SUM_W-tc_pkg::POS_W){1'b0}}, col_pos_reg};
            fg_count_next = fg_count_reg + 1'b1;
        end
    end

    // Advance the raster position.
    always_comb
    begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg + 1'b1;
        if (last)
        begin
            row_pos_next = '0;
            col_pos_next = '0;
        end
        else if (row_end)
        begin
            row_pos_next = row_pos_reg + 1'b1;
            col_pos_next = '0;
        end
    end

    // The job carries the sums as they stand after this pixel.
    always_comb
    begin
        job.fg      = fg;
        job.last    = last;
        job.row_sum = row_sum_next;
        job.col_sum = col_sum_next;
        job.count   = fg_count_next;
    end

    // Frame state; the end of a frame clears everything.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg  <= '0;
            col_pos_reg  <= '0;
            row_sum_reg  <= '0;
            col_sum_reg  <= '0;
            fg_count_reg <= '0;
        end
        else if (accept)
        begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
            if (last)
            begin
                row_sum_reg  <= '0;
                col_sum_reg  <= '0;
                fg_count_reg <= '0;
            end
            else
            begin
                row_sum_reg  <= row_sum_next;
                col_sum_reg  <= col_sum_next;
                fg_count_reg <= fg_count_next;
            end
        end
    end

    `TC_ASSERT_NEXT(a_frame_end_clears, accept && last,
        fg_count_reg == '0 && row_pos_reg == '0 && col_pos_reg == '0,
        "frame state not cleared after the last pixel")
    `TC_ASSERT_NOW(a_width_in_range, 1'b1, width_last_reg < MAX_W_L,
        "stored width exceeds the maximum")

endmodule

`default_nettype wire

### sv/tc_queue.sv
// Short job queue that decouples the front end from the divider back end.
`timescale 1ns / 1ps
`default_nettype none
`include "threshold_centroid_defines.svh"

module tc_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire tc_pkg::tc_job_t push_job,
    output logic                 full,
    input  wire logic            pop,
    output tc_pkg::tc_job_t      head_job,
    output logic                 empty
);

    tc_pkg::tc_job_t entries_reg [tc_pkg::QUEUE_DEPTH];

    logic [tc_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [tc_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [tc_pkg::QCNT_W-1:0] count_reg;
    logic                      do_push;
    logic                      do_pop;

    assign full     = count_reg == tc_pkg::QCNT_W'(tc_pkg::QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = entries_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `TC_ASSERT_NOW(a_queue_bound, 1'b1, count_reg <= tc_pkg::QCNT_W'(tc_pkg::QUEUE_DEPTH),
        "job queue occupancy beyond its depth")

endmodule

`default_nettype wire

### sv/tc_back.sv
// Back end: radix-2 centroid divider and the result output register.
`timescale 1ns / 1ps
`default_nettype none
`include "threshold_centroid_defines.svh"

module tc_back (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire tc_pkg::tc_job_t          head_job,
    input  wire logic                     q_empty,
    output logic                          q_pop,
    input  wire logic                     pop,
    output logic                          empty,
    output logic [tc_pkg::PIX_W-1:0]      binary_pixel,
    output logic                          frame_done,
    output logic [tc_pkg::POS_W-1:0]      centroid_row,
    output logic [tc_pkg::POS_W-1:0]      centroid_col,
    output logic                          empty_frame
);

    localparam int STEP_W = $clog2(tc_pkg::SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(tc_pkg::SUM_W - 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_DIV   = 3'b010,
        S_WRITE = 3'b100
    } tc_back_state_t;

    tc_back_state_t state_reg;
    tc_back_state_t state_next;

    logic [STEP_W-1:0]        step_reg;
    logic [tc_pkg::CNT_W-1:0] divisor_reg;
    logic [tc_pkg::SUM_W-1:0] rq_reg;
    logic [tc_pkg::SUM_W-1:0] cq_reg;
    logic [tc_pkg::CNT_W-1:0] rr_reg;
    logic [tc_pkg::CNT_W-1:0] cr_reg;
    logic                     last_fg_reg;

    logic                     out_valid_reg;
    logic [tc_pkg::PIX_W-1:0] binary_pixel_reg;
    logic                     frame_done_reg;
    logic [tc_pkg::POS_W-1:0] centroid_row_reg;
    logic [tc_pkg::POS_W-1:0] centroid_col_reg;
    logic                     empty_frame_reg;

    logic                   slot_free;
    logic                   needs_div;
    logic                   load_direct;
    logic                   load_div;
    logic [tc_pkg::CNT_W:0] r_trial;
    logic [tc_pkg::CNT_W:0] c_trial;
    logic [tc_pkg::CNT_W:0] r_diff;
    logic [tc_pkg::CNT_W:0] c_diff;
    logic                   r_ge;
    logic                   c_ge;

    // The output slot can take a result if it is empty or being drained now.
    assign slot_free   = !out_valid_reg || pop;
    assign needs_div   = head_job.last && (head_job.count != '0);
    assign q_pop       = (state_reg == S_IDLE) && !q_empty && (slot_free || needs_div);
    assign load_direct = q_pop && !needs_div;
    assign load_div    = (state_reg == S_WRITE) && slot_free;

    // One restoring step for each sum against the shared count.
    always_comb
    begin
        r_trial = {rr_reg, rq_reg[tc_pkg::SUM_W-1]};
        c_trial = {cr_reg, cq_reg[tc_pkg::SUM_W-1]};
        r_diff  = r_trial - {1'b0, divisor_reg};
        c_diff  = c_trial - {1'b0, divisor_reg};
        r_ge    = r_trial >= {1'b0, divisor_reg};
        c_ge    = c_trial >= {1'b0, divisor_reg};
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_pop && needs_div)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DIV)
            begin
                step_reg <= step_reg + 1'b1;
            end
            else
            begin
                step_reg <= '0;
            end
        end
    end

    // Divider datapath: quotient bits shift into the dividend registers.
    // The class of the last pixel is kept for the result written afterwards.
    always_ff @(posedge clk)
    begin
        if (q_pop && needs_div)
        begin
            divisor_reg <= head_job.count;
            rq_reg      <= head_job.row_sum;
            cq_reg      <= head_job.col_sum;
            rr_reg      <= '0;
            cr_reg      <= '0;
            last_fg_reg <= head_job.fg;
        end
        else if (state_reg == S_DIV)
        begin
            rq_reg <= {rq_reg[tc_pkg::SUM_W-2:0], r_ge};
            cq_reg <= {cq_reg[tc_pkg::SUM_W-2:0], c_ge};
            rr_reg <= r_ge ? r_diff[tc_pkg::CNT_W-1:0] : r_trial[tc_pkg::CNT_W-1:0];
            cr_reg <= c_ge ? c_diff[tc_pkg::CNT_W-1:0] : c_trial[tc_pkg::CNT_W-1:0];
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_direct || load_div)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload: plain pixels and empty frames go straight through.
    always_ff @(posedge clk)
    begin
        if (load_direct)
        begin
            binary_pixel_reg <= head_job.fg ? tc_pkg::FG_VALUE : tc_pkg::BG_VALUE;
            frame_done_reg   <= head_job.last;
            centroid_row_reg <= '0;
            centroid_col_reg <= '0;
            empty_frame_reg  <= head_job.last;
        end
        else if (load_div)
        begin
            binary_pixel_reg <= last_fg_reg ? tc_pkg::FG_VALUE : tc_pkg::BG_VALUE;
            frame_done_reg   <= 1'b1;
            centroid_row_reg <= rq_reg[tc_pkg::POS_W-1:0];
            centroid_col_reg <= cq_reg[tc_pkg::POS_W-1:0];
            empty_frame_reg  <= 1'b0;
        end
    end

    assign empty        = !out_valid_reg;
    assign binary_pixel = binary_pixel_reg;
    assign frame_done   = frame_done_reg;
    assign centroid_row = centroid_row_reg;
    assign centroid_col = centroid_col_reg;
    assign empty_frame  = empty_frame_reg;

    `TC_ASSERT_NOW(a_divisor_nonzero, state_reg == S_DIV, divisor_reg != '0,
        "divider running with a zero count")
    `TC_ASSERT_NEXT(a_div_length, state_reg == S_DIV && step_reg == LAST_STEP,
        state_reg == S_WRITE, "divider did not finish after the last step")
    `TC_ASSERT_NOW(a_empty_result, out_valid_reg && empty_frame_reg,
        frame_done_reg && centroid_row_reg == '0 && centroid_col_reg == '0,
        "empty frame result carries a centroid")

endmodule

`default_nettype wire

### sv/threshold_centroid.sv
// Top level of the binary threshold and blob centroid block.
//
//  Channel   Handshake            Payload
//  input     push / full          pixel
//  result    empty / pop          binary_pixel, frame_done, centroid_row,
//                                 centroid_col, empty_frame
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Ordinary pixels flow at one per cycle while results are drained and the
// queue has room; each passes the job queue and the output register before
// it shows on the result ports. A last pixel of a frame with foreground
// pixels holds the back end to load, to divide both sums one bit per cycle
// and to write. Empty frames need no divide and pass like ordinary pixels.
// A four-entry job queue lets the front keep taking pixels meanwhile; once
// it fills, full holds the input until the divider drains it.
// Reset restores the register defaults and clears position, sums and queue.
`timescale 1ns / 1ps
`default_nettype none

module threshold_centroid #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [tc_pkg::PIX_W-1:0]     pixel,
    output logic                              empty,
    input  wire logic                         pop,
    output logic [tc_pkg::PIX_W-1:0]          binary_pixel,
    output logic                              frame_done,
    output logic [tc_pkg::POS_W-1:0]          centroid_row,
    output logic [tc_pkg::POS_W-1:0]          centroid_col,
    output logic                              empty_frame,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [tc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tc_pkg::DIM_W-1:0]     cfg_data
);

    tc_pkg::tc_cfg_wr_t cfg_wr;
    tc_pkg::tc_job_t    front_job;
    tc_pkg::tc_job_t    head_job;
    logic               accept;
    logic               q_empty;
    logic               q_pop;

    // Registers are always writable.
    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    // An input transaction completes when the queue has room.
    assign accept = push && !full;

    tc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_wr (cfg_wr),
        .accept (accept),
        .pixel  (pixel),
        .job    (front_job)
    );

    tc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_job (front_job),
        .full     (full),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    tc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_job     (head_job),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .binary_pixel (binary_pixel),
        .frame_done   (frame_done),
        .centroid_row (centroid_row),
        .centroid_col (centroid_col),
        .empty_frame  (empty_frame)
    );

endmodule

`default_nettype wire
